FILE: src/imhq_pkg.sv
`timescale 1ns / 1ps
package imhq_pkg;
  localparam int NumVertices = 256;
  localparam int VtxW = 8;
  localparam int SlotW = 8;
  localparam int CntW = 9;
  localparam int KeyW = 31;

  localparam logic [1:0] ReqInsert = 2'd0;
  localparam logic [1:0] ReqDecrease = 2'd1;
  localparam logic [1:0] ReqExtract = 2'd2;

  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StDupInsert = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;
  localparam logic [1:0] StDecIgnored = 2'd3;

  typedef struct packed {
    logic [VtxW-1:0] vtx;
    logic [KeyW-1:0] key;
  } heap_slot_t;

  typedef enum logic [3:0] {
    CmdNone, CmdLoad, CmdRdPos, CmdRdCur, CmdDecide, CmdInsWr, CmdDecWr, CmdExtTop,
    CmdExtLast, CmdRdPar, CmdUpStep, CmdRdKids, CmdDnStep, CmdFinish
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       ins_ok;
    logic       dec_ok;
    logic       ext_ok;
    logic       ext_more;
    logic       up_swap;
    logic       up_root;
    logic       dn_swap;
  } dp_status_t;
endpackage

FILE: src/imhq_if.sv
`timescale 1ns / 1ps
interface imhq_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [imhq_pkg::VtxW-1:0]  vertex;
  logic [imhq_pkg::KeyW-1:0]  distance;
  modport source(output valid, req_type, vertex, distance, input ready);
  modport sink(input valid, req_type, vertex, distance, output ready);
endinterface

interface imhq_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [imhq_pkg::VtxW-1:0]  out_vertex;
  logic [imhq_pkg::KeyW-1:0]  out_distance;
  logic                       vertex_queued;
  logic                       queue_empty;
  logic [imhq_pkg::CntW-1:0]  entry_count;
  modport source(output valid, status, out_vertex, out_distance, vertex_queued,
                 queue_empty, entry_count, input ready);
  modport sink(input valid, status, out_vertex, out_distance, vertex_queued,
               queue_empty, entry_count, output ready);
endinterface

FILE: src/indexed_min_heap_queue_unit.sv
`timescale 1ns / 1ps
// Indexed binary min-heap priority queue of up to 256 vertices keyed by
// 31-bit distance. The in_ channel carries a request (insert, decrease,
// extract minimum), the out_ channel returns exactly one result per request
// with a status, the extracted entry, the request vertex's presence and the
// entry count after the step.
// One request is processed at a time. After the request transfer the block
// reads the vertex position and the heap slots, decides, then walks the
// moving entry through the heap memory one level per step, within the heap's
// eight levels, and registers the result; the block is ready for the next
// request as soon as the result is registered.
// The result waits in an output register; while the receiver stalls, the
// block takes one more request, walks it and then holds until the waiting
// result is transferred.
// Synchronous active-low reset empties the queue and marks every vertex
// absent at once; no clearing pass is needed.
module indexed_min_heap_queue_unit (
  input logic clk,
  input logic rst_n,
  imhq_in_if.sink    in,
  imhq_out_if.source out
);
  imhq_pkg::dp_cmd_t    cmd;
  imhq_pkg::dp_status_t st;
  logic                 in_ready;

  assign in.ready = in_ready;

  imhq_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire(in.valid && in_ready),
    .out_busy(out.valid),
    .st, .cmd, .in_ready
  );

  imhq_dp u_dp (
    .clk, .rst_n, .cmd,
    .in_req(in.req_type), .in_vtx(in.vertex), .in_dist(in.distance),
    .st, .out
  );
endmodule

FILE: src/imhq_ctrl.sv
`timescale 1ns / 1ps
module imhq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  logic                  out_busy,
  input  imhq_pkg::dp_status_t  st,
  output imhq_pkg::dp_cmd_t     cmd,
  output logic                  in_ready
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_POS  = 4'd1;
  localparam logic [3:0] S_CUR  = 4'd2;
  localparam logic [3:0] S_DEC  = 4'd3;
  localparam logic [3:0] S_UPR  = 4'd4;
  localparam logic [3:0] S_UPS  = 4'd5;
  localparam logic [3:0] S_DNR  = 4'd6;
  localparam logic [3:0] S_DNS  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = imhq_pkg::CmdNone;
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        cmd = imhq_pkg::CmdLoad;
        state_nxt = S_POS;
      end
      S_POS: begin
        cmd = imhq_pkg::CmdRdPos;
        state_nxt = S_CUR;
      end
      S_CUR: begin
        cmd = imhq_pkg::CmdRdCur;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        // Position and slot data are registered; decide what the request does.
        if (st.req == imhq_pkg::ReqInsert && st.ins_ok) begin
          cmd = imhq_pkg::CmdInsWr;
          state_nxt = S_UPR;
        end else if (st.req == imhq_pkg::ReqDecrease && st.dec_ok) begin
          cmd = imhq_pkg::CmdDecWr;
          state_nxt = S_UPR;
        end else if (st.req == imhq_pkg::ReqExtract && st.ext_ok) begin
          cmd = st.ext_more ? imhq_pkg::CmdExtLast : imhq_pkg::CmdExtTop;
          state_nxt = st.ext_more ? S_DNR : S_FIN;
        end else begin
          cmd = imhq_pkg::CmdDecide;
          state_nxt = S_FIN;
        end
      end
      S_UPR: begin
        if (st.up_root) state_nxt = S_FIN;
        else begin
          cmd = imhq_pkg::CmdRdPar;
          state_nxt = S_UPS;
        end
      end
      S_UPS: begin
        if (st.up_swap) begin
          cmd = imhq_pkg::CmdUpStep;
          state_nxt = S_UPR;
        end else state_nxt = S_FIN;
      end
      S_DNR: begin
        cmd = imhq_pkg::CmdRdKids;
        state_nxt = S_DNS;
      end
      S_DNS: begin
        if (st.dn_swap) begin
          cmd = imhq_pkg::CmdDnStep;
          state_nxt = S_DNR;
        end else state_nxt = S_FIN;
      end
      S_FIN: if (!out_busy) begin
        cmd = imhq_pkg::CmdFinish;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

FILE: src/imhq_dp.sv
`timescale 1ns / 1ps
module imhq_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  imhq_pkg::dp_cmd_t          cmd,
  input  logic [1:0]                 in_req,
  input  logic [imhq_pkg::VtxW-1:0]  in_vtx,
  input  logic [imhq_pkg::KeyW-1:0]  in_dist,
  output imhq_pkg::dp_status_t       st,
  imhq_out_if.source                 out
);
  localparam int SW = imhq_pkg::SlotW;
  localparam int CW = imhq_pkg::CntW;
  localparam int N = imhq_pkg::NumVertices;

  // Heap memory: reads are sequenced by the controller, at most two slots a
  // cycle. A shadow of the current node is kept in registers.
  imhq_pkg::heap_slot_t heap_mem [N];
  logic [SW-1:0] pos_mem [N];
  logic [N-1:0]  pos_vld_r;

  logic [1:0]          req_r;
  logic [imhq_pkg::VtxW-1:0] vtx_r;
  logic [imhq_pkg::KeyW-1:0] dist_r;
  logic [CW-1:0]       cnt_r;
  logic [SW-1:0]       pos_rd_r;
  imhq_pkg::heap_slot_t top_r, last_r, cur_r, par_r, lc_r, rc_r;
  logic [SW-1:0]       idx_r;
  logic [1:0]          status_r;
  logic [imhq_pkg::VtxW-1:0] ov_r;
  logic [imhq_pkg::KeyW-1:0] od_r;
  logic                out_valid_r;
  logic                fin_move_r;

  // Result register; it lets the next request walk while a result waits.
  logic [1:0]                res_status_r;
  logic [imhq_pkg::VtxW-1:0] res_vtx_r;
  logic [imhq_pkg::KeyW-1:0] res_dist_r;
  logic                      res_queued_r;
  logic                      res_empty_r;
  logic [CW-1:0]             res_count_r;

  logic [SW-1:0] par_idx, lc_idx, rc_idx, best_idx;
  logic [CW-1:0] lc_w, rc_w;
  logic          lc_in, rc_in, pick_l, pick_r;
  imhq_pkg::heap_slot_t best_s;

  assign par_idx = (idx_r - SW'(1)) >> 1;
  assign lc_w = {idx_r, 1'b1};
  assign rc_w = {idx_r, 1'b0} + CW'(2);
  assign lc_idx = lc_w[SW-1:0];
  assign rc_idx = rc_w[SW-1:0];
  assign lc_in = lc_w < cnt_r;
  assign rc_in = rc_w < cnt_r;
  assign pick_l = lc_in && (lc_r.key < cur_r.key);
  always_comb begin
    pick_r = 1'b0;
    if (rc_in) pick_r = pick_l ? (rc_r.key < lc_r.key) : (rc_r.key < cur_r.key);
    best_idx = pick_r ? rc_idx : lc_idx;
    best_s = pick_r ? rc_r : lc_r;
  end

  assign st.req = req_r;
  assign st.ins_ok = !pos_vld_r[vtx_r] && (cnt_r < CW'(N));
  assign st.dec_ok = pos_vld_r[vtx_r] && (dist_r < cur_r.key);
  assign st.ext_ok = cnt_r != '0;
  assign st.ext_more = cnt_r > CW'(1);
  assign st.up_root = idx_r == '0;
  assign st.up_swap = cur_r.key < par_r.key;
  assign st.dn_swap = pick_l || pick_r;

  // Memory accesses. Reads are registered; only one write to each memory per cycle.
  always_ff @(posedge clk) begin
    unique case (cmd)
      imhq_pkg::CmdRdPos:  begin
        pos_rd_r <= pos_mem[vtx_r];
        top_r <= heap_mem[0];
        last_r <= heap_mem[SW'(cnt_r - CW'(1))];
      end
      imhq_pkg::CmdRdCur: cur_r <= heap_mem[pos_rd_r];
      imhq_pkg::CmdInsWr: begin
        heap_mem[cnt_r[SW-1:0]] <= '{vtx: vtx_r, key: dist_r};
        pos_mem[vtx_r] <= cnt_r[SW-1:0];
        cur_r <= '{vtx: vtx_r, key: dist_r};
        idx_r <= cnt_r[SW-1:0];
      end
      imhq_pkg::CmdDecWr: begin
        heap_mem[pos_rd_r] <= '{vtx: vtx_r, key: dist_r};
        cur_r <= '{vtx: vtx_r, key: dist_r};
        idx_r <= pos_rd_r;
      end
      imhq_pkg::CmdExtLast: begin
        heap_mem[0] <= last_r;
        pos_mem[last_r.vtx] <= '0;
        cur_r <= last_r;
        idx_r <= '0;
      end
      imhq_pkg::CmdRdPar: par_r <= heap_mem[par_idx];
      imhq_pkg::CmdUpStep: begin
        heap_mem[idx_r] <= par_r;
        pos_mem[par_r.vtx] <= idx_r;
        idx_r <= par_idx;
      end
      imhq_pkg::CmdRdKids: begin
        lc_r <= heap_mem[lc_idx];
        rc_r <= heap_mem[rc_idx];
      end
      imhq_pkg::CmdDnStep: begin
        heap_mem[idx_r] <= best_s;
        pos_mem[best_s.vtx] <= idx_r;
        idx_r <= best_idx;
      end
      default: ;
    endcase
    // The moving entry lands in its final slot when the walk ends.
    if (cmd == imhq_pkg::CmdFinish && (req_r == imhq_pkg::ReqInsert ||
        req_r == imhq_pkg::ReqDecrease || req_r == imhq_pkg::ReqExtract) &&
        status_r == imhq_pkg::StDone && cnt_r != '0 && fin_move_r) begin
      heap_mem[idx_r] <= cur_r;
      pos_mem[cur_r.vtx] <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_vld_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      fin_move_r <= 1'b0;
    end else begin
      if (out_valid_r && out.ready) out_valid_r <= 1'b0;
      unique case (cmd)
        imhq_pkg::CmdLoad: begin
          req_r <= in_req;
          vtx_r <= in_vtx;
          dist_r <= in_dist;
          status_r <= imhq_pkg::StDone;
          ov_r <= '0;
          od_r <= '0;
          fin_move_r <= 1'b0;
        end
        imhq_pkg::CmdDecide: begin
          if (req_r == imhq_pkg::ReqInsert) status_r <= imhq_pkg::StDupInsert;
          else if (req_r == imhq_pkg::ReqDecrease) status_r <= imhq_pkg::StDecIgnored;
          else if (req_r == imhq_pkg::ReqExtract) status_r <= imhq_pkg::StEmpty;
        end
        imhq_pkg::CmdInsWr: begin
          pos_vld_r[vtx_r] <= 1'b1;
          cnt_r <= cnt_r + CW'(1);
          fin_move_r <= 1'b1;
        end
        imhq_pkg::CmdDecWr: fin_move_r <= 1'b1;
        imhq_pkg::CmdExtTop, imhq_pkg::CmdExtLast: begin
          pos_vld_r[top_r.vtx] <= 1'b0;
          cnt_r <= cnt_r - CW'(1);
          ov_r <= top_r.vtx;
          od_r <= top_r.key;
          fin_move_r <= (cmd == imhq_pkg::CmdExtLast);
        end
        imhq_pkg::CmdFinish: begin
          out_valid_r <= 1'b1;
          res_status_r <= status_r;
          res_vtx_r <= ov_r;
          res_dist_r <= od_r;
          res_queued_r <= pos_vld_r[vtx_r];
          res_empty_r <= cnt_r == '0;
          res_count_r <= cnt_r;
        end
        default: ;
      endcase
    end
  end

  assign out.valid = out_valid_r;
  assign out.status = res_status_r;
  assign out.out_vertex = res_vtx_r;
  assign out.out_distance = res_dist_r;
  assign out.vertex_queued = res_queued_r;
  assign out.queue_empty = res_empty_r;
  assign out.entry_count = res_count_r;
endmodule

FILE: src/imhq_checker.sv
`timescale 1ns / 1ps
module imhq_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] status,
  input logic queue_empty,
  input logic [imhq_pkg::CntW-1:0] entry_count
);
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (queue_empty == (entry_count == '0))) else $error("empty flag");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> entry_count <= imhq_pkg::CntW'(imhq_pkg::NumVertices))
    else $error("count range");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after transfer");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(status)) else $error("hold");
endmodule

bind indexed_min_heap_queue_unit imhq_checker u_chk (
  .clk, .rst_n, .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready), .status(out.status),
  .queue_empty(out.queue_empty), .entry_count(out.entry_count)
);

FILE: dv/imhq_test_if.sv
`timescale 1ns / 1ps
// The block's channel interfaces live in the RTL source; this file carries
// the testbench's own small helper interface for the stall control.
interface imhq_stall_ctl_if;
  logic hold_long;
  logic quiet;
  modport source(output hold_long, quiet);
  modport sink(input hold_long, quiet);
endinterface

FILE: dv/indexed_min_heap_queue_unit_test.sv
`timescale 1ns / 1ps
module indexed_min_heap_queue_unit_test;
  localparam int VtxW = imhq_pkg::VtxW;
  localparam int KeyW = imhq_pkg::KeyW;
  localparam int CntW = imhq_pkg::CntW;
  localparam int NumVertices = imhq_pkg::NumVertices;
  localparam logic [1:0] ReqInsert = imhq_pkg::ReqInsert;
  localparam logic [1:0] ReqDecrease = imhq_pkg::ReqDecrease;
  localparam logic [1:0] ReqExtract = imhq_pkg::ReqExtract;
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam logic [1:0] StDone = imhq_pkg::StDone;
  localparam logic [1:0] StDupInsert = imhq_pkg::StDupInsert;
  localparam logic [1:0] StEmpty = imhq_pkg::StEmpty;
  localparam logic [1:0] StDecIgnored = imhq_pkg::StDecIgnored;

  typedef struct packed {
    logic [1:0]      status;
    logic [VtxW-1:0] vtx;
    logic [KeyW-1:0] key;
    logic            queued;
    logic            empty;
    logic [CntW-1:0] count;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  imhq_in_if in_ch();
  imhq_out_if out_ch();
  imhq_stall_ctl_if stall_ctl();

  indexed_min_heap_queue_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in(in_ch.sink),
    .out(out_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow priority queue.
  logic [VtxW-1:0] pq_vtx [NumVertices];
  logic [KeyW-1:0] pq_key [NumVertices];
  int unsigned     pq_slot [NumVertices];
  bit              pq_present [NumVertices];
  int unsigned     pq_count;

  heap_result_t expected_results [$];
  int mismatch_count = 0;
  int received_count = 0;

  initial begin
    for (int i = 0; i < NumVertices; i++) pq_present[i] = 1'b0;
    pq_count = 0;
  end

  function automatic void pq_swap(int unsigned a, int unsigned b);
    logic [VtxW-1:0] tv;
    logic [KeyW-1:0] tk;
    tv = pq_vtx[a]; tk = pq_key[a];
    pq_vtx[a] = pq_vtx[b]; pq_key[a] = pq_key[b];
    pq_vtx[b] = tv; pq_key[b] = tk;
    pq_slot[pq_vtx[a]] = a;
    pq_slot[pq_vtx[b]] = b;
  endfunction

  function automatic void pq_raise(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(pq_key[i] < pq_key[p])) break;
      pq_swap(i, p);
      i = p;
    end
  endfunction

  function automatic void pq_lower(int unsigned i);
    int unsigned best;
    int unsigned l;
    int unsigned r;
    forever begin
      best = i;
      l = 2 * i + 1;
      r = 2 * i + 2;
      if (l < pq_count && pq_key[l] < pq_key[best]) best = l;
      if (r < pq_count && pq_key[r] < pq_key[best]) best = r;
      if (best == i) break;
      pq_swap(i, best);
      i = best;
    end
  endfunction

  function automatic heap_result_t pq_apply(logic [1:0] req, logic [VtxW-1:0] v,
                                            logic [KeyW-1:0] d);
    heap_result_t r;
    int unsigned s;
    r = '0;
    r.status = StDone;
    if (req == ReqInsert) begin
      if (pq_present[v] || pq_count >= NumVertices) begin
        r.status = StDupInsert;
      end else begin
        s = pq_count;
        pq_vtx[s] = v;
        pq_key[s] = d;
        pq_slot[v] = s;
        pq_present[v] = 1'b1;
        pq_count = s + 1;
        pq_raise(s);
      end
    end else if (req == ReqDecrease) begin
      if (!pq_present[v] || pq_key[pq_slot[v]] <= d) begin
        r.status = StDecIgnored;
      end else begin
        s = pq_slot[v];
        pq_key[s] = d;
        pq_raise(s);
      end
    end else if (req == ReqExtract) begin
      if (pq_count == 0) begin
        r.status = StEmpty;
      end else begin
        r.vtx = pq_vtx[0];
        r.key = pq_key[0];
        pq_present[pq_vtx[0]] = 1'b0;
        pq_count--;
        if (pq_count > 0) begin
          pq_vtx[0] = pq_vtx[pq_count];
          pq_key[0] = pq_key[pq_count];
          pq_slot[pq_vtx[0]] = 0;
          pq_lower(0);
        end
      end
    end
    r.queued = pq_present[v];
    r.empty = (pq_count == 0);
    r.count = CntW'(pq_count);
    return r;
  endfunction

  // Sender side.
  bit sender_idle_en = 1'b1;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = ReqInsert;
    in_ch.vertex = '0;
    in_ch.distance = '0;
    stall_ctl.hold_long = 1'b0;
    stall_ctl.quiet = 1'b0;
  end

  // Valid stays high across back-to-back requests; it drops only for idling and while the bench waits to drain.
  task automatic send_request(input logic [1:0] req, input logic [VtxW-1:0] v,
                              input logic [KeyW-1:0] d);
    int gap;
    if (sender_idle_en && !stall_ctl.quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.vertex <= v;
    in_ch.distance <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(pq_apply(req, v, d));
  endtask

  // Receiver side.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_ctl.hold_long) begin
        out_ch.ready <= 1'b0;
      end else if (!stall_ctl.quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    heap_result_t got;
    heap_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status = out_ch.status;
      got.vtx = out_ch.out_vertex;
      got.key = out_ch.out_distance;
      got.queued = out_ch.vertex_queued;
      got.empty = out_ch.queue_empty;
      got.count = out_ch.entry_count;
      received_count++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"Mismatch: status %0d/%0d vtx %0d/%0d dist %0d/%0d",
                      " q %b/%b e %b/%b n %0d/%0d"},
                     want.status, got.status, want.vtx, got.vtx, want.key, got.key,
                     want.queued, got.queued, want.empty, got.empty, want.count, got.count);
        end
      end
    end
  end

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KeyW-1:0] rand_key();
    case ($urandom_range(0, 3))
      0: return KeyW'($urandom_range(0, 15));
      1: return {KeyW{1'b1}} - KeyW'($urandom_range(0, 3));
      default: return KeyW'($urandom());
    endcase
  endfunction

  // Directed: extremes, every request kind and each corner case.
  task automatic test_directed();
    send_request(ReqExtract, 8'd0, '0);
    send_request(ReqDecrease, 8'd5, 31'd1);
    send_request(ReqInsert, 8'd255, {KeyW{1'b1}});
    send_request(ReqInsert, 8'd0, 31'd0);
    send_request(ReqInsert, 8'd0, 31'd7);
    send_request(ReqInsert, 8'd10, 31'd0);
    send_request(ReqInsert, 8'd20, 31'h2AAA_AAAA);
    send_request(ReqDecrease, 8'd20, 31'h2AAA_AAAA);
    send_request(ReqDecrease, 8'd20, 31'h5555_5555);
    send_request(ReqDecrease, 8'd255, 31'd3);
    send_request(ReqDecrease, 8'd20, 31'd0);
    send_request(ReqUnused, 8'd20, 31'd9);
    send_request(ReqExtract, 8'd0, '0);
    send_request(ReqExtract, 8'd20, '0);
    send_request(ReqExtract, 8'd10, '0);
    send_request(ReqExtract, 8'd255, '0);
    send_request(ReqExtract, 8'd255, '0);
    send_request(ReqInsert, 8'h55, {KeyW{1'b1}});
    send_request(ReqExtract, 8'h55, '0);
    wait_drained();
  endtask

  // Fill the queue completely, try one more, apply random decreases, then drain it in order.
  task automatic test_full_queue();
    for (int i = 0; i < NumVertices; i++) send_request(ReqInsert, VtxW'(i), rand_key());
    send_request(ReqInsert, 8'd7, 31'd1);
    for (int i = 0; i < 40; i++)
      send_request(ReqDecrease, VtxW'($urandom_range(0, 255)),
                   KeyW'($urandom_range(0, 1000)));
    for (int i = 0; i <= NumVertices; i++)
      send_request(ReqExtract, VtxW'($urandom_range(0, 255)), KeyW'($urandom()));
    wait_drained();
  endtask

  // The receiver holds off while the sender keeps offering requests.
  task automatic test_output_backpressure();
    stall_ctl.hold_long <= 1'b1;
    fork
      for (int i = 0; i < 8; i++) send_request(ReqInsert, VtxW'(100 + i), rand_key());
      repeat (300) @(posedge clk);
    join_any
    stall_ctl.hold_long <= 1'b0;
    wait fork;
    for (int i = 0; i < 8; i++) send_request(ReqExtract, VtxW'(100 + i), '0);
    wait_drained();
  endtask

  // Random mix over vertices 0 to vmax; a small vertex set makes duplicates and decreases hit.
  task automatic test_random_mix(input int n, input int unsigned vmax);
    logic [1:0] req;
    logic [VtxW-1:0] v;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) req = ReqInsert;
      else if (sel < 65) req = ReqDecrease;
      else if (sel < 97) req = ReqExtract;
      else req = ReqUnused;
      v = VtxW'($urandom_range(0, vmax));
      send_request(req, v, rand_key());
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_queue();
    test_output_backpressure();
    test_random_mix(300, 255);
    test_random_mix(300, 31);
    // Last part runs at full rate on both sides.
    stall_ctl.quiet <= 1'b1;
    test_random_mix(150, 15);
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
